>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, operation and status codes, and the command struct
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_REMOVE     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } bdq_cmd_t;

endpackage

>>> rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: takes one item, runs it through the datapath, then holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bdq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/bdq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dpath
// Entry cells with per-cell compare and shift, the entry count and the
// result registers.
// ----------------------------------------------------------------------------
module bdq_dpath
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  bdq_cmd_t                 cmd,
  input  logic [2:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_operand,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_popped,
  output logic [CNT_W-1:0]         out_occupancy
);

  logic [2:0]        kind_r;
  logic [DATA_W-1:0] oper_r;

  logic [DATA_W-1:0] entries_r   [DEPTH];
  logic [DATA_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [DATA_W-1:0] popped_r;
  logic [DATA_W-1:0] popped_nxt;
  logic [CNT_W-1:0]  occ_r;

  logic [DEPTH-1:0]  match;
  logic [IDX_W-1:0]  back_idx;
  logic [IDX_W-1:0]  rm_pos;
  logic              rm_hit;
  logic              full;
  logic              empty;

  assign full     = (count_r >= CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign back_idx = IDX_W'(count_r - CNT_W'(1));

  // Every held cell compares against the operand at once.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (entries_r[i] == oper_r) && (CNT_W'(i) < count_r);
    end
  end

  // Front first, then back, then the lowest matching cell in between.
  always_comb begin
    rm_pos = '0;
    rm_hit = 1'b0;
    for (int i = DEPTH - 1; i >= 1; i--) begin
      if (match[i]) begin
        rm_pos = IDX_W'(i);
        rm_hit = 1'b1;
      end
    end
    if (!empty && match[back_idx]) begin
      rm_pos = back_idx;
      rm_hit = 1'b1;
    end
    if (match[0]) begin
      rm_pos = '0;
      rm_hit = 1'b1;
    end
  end

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    popped_nxt  = '0;
    case (kind_r)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 1; i < DEPTH; i++) begin
            entries_nxt[i] = entries_r[i-1];
          end
          entries_nxt[0] = oper_r;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          entries_nxt[IDX_W'(count_r)] = oper_r;
          count_nxt                    = count_r + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = entries_r[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            entries_nxt[i] = entries_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = entries_r[back_idx];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!rm_hit) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          // Cells at and above the hit take their upper neighbour's value.
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (i >= int'(rm_pos)) entries_nxt[i] = entries_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      oper_r <= in_operand;
    end
    if (cmd.exec) begin
      entries_r <= entries_nxt;
      status_r  <= status_nxt;
      popped_r  <= popped_nxt;
      occ_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_popped    = popped_r;
  assign out_occupancy = occ_r;

endmodule

>>> rtl/bounded_deque_remove_by_value_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_remove_by_value_unit
// Bounded double-ended queue of signed 32-bit values with remove by value.
//
// The input channel (in_valid/in_ready) carries one item: an operation code
// in in_kind and a value in in_operand. The result channel
// (out_valid/out_ready) returns one item per input item: a status, the
// popped value (zero unless a pop succeeded) and the occupancy afterwards.
// The accepted item is executed in the EXEC state, and out_valid rises as
// the controller then moves on to the RESP state. One item is in flight at
// a time: a new item is taken in the cycle after the result is taken.
// Every operation, remove by value included, is done in the EXEC state by
// per-cell compare and shift.
// While the receiver stalls the result is held and no new item is taken.
// Reset empties the store; entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_remove_by_value_unit
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_popped,
  output logic [CNT_W-1:0]         out_occupancy
);

  bdq_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bdq_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_operand    (in_operand),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_occupancy (out_occupancy)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque with remove by value. A driver
// feeds operations from a backlog that the stimulus block fills; a shadow
// deque computes the expected result for every accepted item, and a monitor
// compares each returned result field by field, in order. Both handshakes
// idle at random, except over one long quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  // Codes five to seven carry no operation; the block only reports on them.
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_OPS = 400;

  typedef struct {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] operand;
    bit                       drain_first;
  } deque_op_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped;
    logic [CNT_W-1:0]         occupancy;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_kind = '0;
  logic signed [DATA_W-1:0] in_operand = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_popped;
  logic [CNT_W-1:0]         out_occupancy;

  deque_op_t     op_backlog[$];
  deque_result_t awaited_results[$];
  deque_op_t     next_op;
  deque_result_t seen;

  // Shadow copy of the deque, front at position zero.
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;

  int accepted_total = 0;
  int fail_count = 0;

  bounded_deque_remove_by_value_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_popped    (out_popped),
    .out_occupancy (out_occupancy)
  );

  always #5 clk = ~clk;

  function automatic void drop_entry(int pos);
    for (int i = pos; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
  endfunction

  function automatic deque_result_t apply_op(logic [2:0] kind,
                                             logic signed [DATA_W-1:0] value);
    deque_result_t r;
    int            hit;
    r.status = ST_OK;
    r.popped = '0;
    hit = -1;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (kind == KIND_PUSH_FRONT) begin
          for (int i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[0] = value;
          shadow_count++;
        end else begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_entries[0];
          drop_entry(0);
        end
      end
      KIND_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_entries[shadow_count - 1];
          shadow_count--;
        end
      end
      KIND_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Front first, then back, then the inner entries from the front.
          if (shadow_entries[0] == value) hit = 0;
          else if (shadow_entries[shadow_count - 1] == value) hit = shadow_count - 1;
          else begin
            for (int i = 1; i < shadow_count - 1 && hit < 0; i++) begin
              if (shadow_entries[i] == value) hit = i;
            end
          end
          if (hit < 0) r.status = ST_NOTFOUND;
          else drop_entry(hit);
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // No idling at all over a long stretch in the middle of the run.
  function automatic bit take_break();
    if (accepted_total >= 150 && accepted_total < 260) return 1'b0;
    return $urandom_range(0, 99) < 12;
  endfunction

  // Mostly a small pool so that removes find matches and duplicates occur.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $signed(32'($urandom_range(0, 7))) - 4;
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic void add_op(logic [2:0] kind, logic signed [DATA_W-1:0] operand,
                                 bit drain_first);
    deque_op_t op;
    op.kind = kind;
    op.operand = operand;
    op.drain_first = drain_first;
    op_backlog.push_back(op);
  endfunction

  // Driver: predicts on every accepted item, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_op(in_kind, in_operand));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (op_backlog.size() != 0 && !take_break() &&
            !(op_backlog[0].drain_first && awaited_results.size() != 0)) begin
          next_op = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_op.kind;
          in_operand <= next_op.operand;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each returned item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result item: status %0d popped %0d occupancy %0d",
                 out_status, out_popped, out_occupancy);
          fail_count++;
        end else begin
          seen = awaited_results.pop_front();
          if (out_status !== seen.status) begin
            $error("status: expected %0d, got %0d", seen.status, out_status);
            fail_count++;
          end
          if (out_popped !== seen.popped) begin
            $error("popped: expected %0d, got %0d", seen.popped, out_popped);
            fail_count++;
          end
          if (out_occupancy !== seen.occupancy) begin
            $error("occupancy: expected %0d, got %0d", seen.occupancy, out_occupancy);
            fail_count++;
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  initial begin
    int mode;
    int seg_len;
    int counted;
    int r;
    logic [2:0] kind;

    // Empty store first, then extremes, end matches and an inner match.
    add_op(KIND_POP_FRONT, 32'sd9, 1'b0);
    add_op(KIND_POP_BACK, -32'sd9, 1'b0);
    add_op(KIND_REMOVE, 32'sd0, 1'b0);
    add_op(KIND_PUSH_BACK, VAL_MAX, 1'b0);
    add_op(KIND_PUSH_FRONT, VAL_MIN, 1'b0);
    add_op(KIND_PUSH_BACK, 32'sd7, 1'b0);
    add_op(KIND_PUSH_FRONT, 32'sd7, 1'b0);
    add_op(KIND_REMOVE, 32'sd7, 1'b0);
    add_op(KIND_REMOVE, 32'sd7, 1'b0);
    add_op(KIND_PUSH_BACK, 32'sd0, 1'b0);
    add_op(KIND_PUSH_BACK, -32'sd1, 1'b0);
    add_op(KIND_REMOVE, 32'sd0, 1'b0);
    add_op(KIND_REMOVE, 32'sd12345, 1'b0);
    add_op(KIND_REMOVE, VAL_MAX, 1'b0);
    add_op(KIND_SPARE_5, VAL_MAX, 1'b0);
    add_op(KIND_SPARE_6, VAL_MIN, 1'b0);
    add_op(KIND_SPARE_7, -32'sd1, 1'b0);
    add_op(KIND_POP_FRONT, 32'sd0, 1'b0);
    add_op(KIND_POP_BACK, 32'sd0, 1'b0);
    add_op(KIND_POP_BACK, 32'sd0, 1'b0);

    // Fill past the top so that pushes into a full store are seen early.
    for (int i = 0; i < DEPTH + 3; i++) begin
      add_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value(), i == 0);
    end

    counted = DEPTH + 3;
    while (counted < RANDOM_OPS) begin
      mode = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 50);
      for (int i = 0; i < seg_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < (mode == 0 ? 75 : mode == 1 ? 25 : 40)) begin
          kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else if (r < (mode == 0 ? 85 : mode == 1 ? 75 : 65)) begin
          kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        end else if (r < 97) begin
          kind = KIND_REMOVE;
        end else begin
          kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
        end
        add_op(kind, pick_value(), i == 0 && $urandom_range(0, 3) == 0);
        if (kind <= KIND_REMOVE) counted++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_dpath.sv
rtl/bounded_deque_remove_by_value_unit.sv
sim/tb_top.sv
